>>> sv/rslp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remote status line parser package
// Beat types, event codes, keyword table and value-scaling constants.
// ----------------------------------------------------------------------------
package rslp_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       line_end;
  } in_beat_t;

  typedef struct packed {
    logic        parse_ok;
    logic [3:0]  event_kind;
    logic [7:0]  node_id;
    logic [31:0] status_value;
  } out_beat_t;

  typedef enum logic [3:0] {
    KIND_NONE  = 4'd0,
    KIND_RUN   = 4'd1,
    KIND_STOP  = 4'd2,
    KIND_VOLT  = 4'd3,
    KIND_PHASE = 4'd4,
    KIND_TRIP  = 4'd5,
    KIND_FREQ  = 4'd6,
    KIND_READY = 4'd7,
    KIND_MCLK  = 4'd8
  } event_kind_e;

  typedef struct packed {
    event_kind_e event_kind;
    logic [7:0]  node_id;
    logic [31:0] magnitude;
    logic        overflow;
    logic        negative;
  } line_sum_t;

  localparam int KW_COUNT   = 8;
  localparam int KW_MAX_LEN = 10;

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"r", "u", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "t", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "t", "a", "t", ":", "v", "o", "l", "t", 8'h00},
    '{"s", "t", "a", "t", ":", "p", "h", "a", "s", 8'h00},
    '{"s", "t", "a", "t", ":", "t", "c", "u", "r", "r"},
    '{"s", "t", "a", "t", ":", "f", "r", "e", "q", 8'h00},
    '{"s", "t", "a", "t", ":", "r", "e", "a", "d", "y"},
    '{"s", "t", "a", "t", ":", "m", "c", "l", "k", 8'h00}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd4, 4'd9, 4'd9, 4'd10, 4'd9, 4'd10, 4'd9
  };

  localparam logic [7:0]  NO_NODE    = 8'hFF;
  localparam logic [31:0] SIGNED_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

  // floor(n / 1000) == (n * VOLT_RECIP) >> VOLT_SHIFT for every n below 2^31
  localparam logic [31:0] VOLT_RECIP = 32'd2199023256;
  localparam int          VOLT_SHIFT = 41;
  localparam int          QUOT_W     = 22;

  function automatic logic [7:0] kw_char(logic [2:0] idx, logic [3:0] off);
    logic [7:0] r;
    r = 8'h00;
    if (off < 4'(KW_MAX_LEN)) begin
      r = KW_TEXT[idx][off];
    end
    return r;
  endfunction

endpackage

>>> sv/rslp_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remote status line parser: result finishing pipeline
// Clamps the magnitude, scales volts by 1/1000, applies the sign and
// registers the result beat with its own valid/stall handshake.
// ----------------------------------------------------------------------------
module rslp_finish (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  sum_valid_i,
  input  rslp_pkg::line_sum_t   sum_i,
  output logic                  sum_ready_o,
  output logic                  out_valid_o,
  output rslp_pkg::out_beat_t   out_data_o,
  input  logic                  out_stall_i
);

  logic                        out_ready, c_ready, b_ready;
  logic                        b_valid_q;
  rslp_pkg::line_sum_t         b_sum_q;
  logic                        b_signed;
  logic [31:0]                 b_base;
  logic [62:0]                 b_prod;

  logic                        c_valid_q;
  rslp_pkg::event_kind_e       c_kind_q;
  logic [7:0]                  c_id_q;
  logic [31:0]                 c_base_q;
  logic [rslp_pkg::QUOT_W-1:0] c_quot_q;
  logic                        c_ovf_q;
  logic                        c_neg_q;
  logic [31:0]                 c_mag;
  logic [31:0]                 c_value;

  logic                        out_valid_q;
  rslp_pkg::out_beat_t         out_data_q;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign c_ready     = !c_valid_q || out_ready;
  assign b_ready     = !b_valid_q || c_ready;
  assign sum_ready_o = b_ready;

  always_comb begin
    b_signed = (b_sum_q.event_kind inside
                {rslp_pkg::KIND_VOLT, rslp_pkg::KIND_PHASE, rslp_pkg::KIND_TRIP});
    b_base   = b_sum_q.magnitude;
    if (b_signed && (b_sum_q.overflow || b_sum_q.magnitude[31])) begin
      b_base = rslp_pkg::SIGNED_MAX;
    end
    b_prod = b_base[30:0] * rslp_pkg::VOLT_RECIP;
  end

  always_comb begin
    c_mag = c_base_q;
    if (c_kind_q == rslp_pkg::KIND_VOLT) begin
      c_mag = 32'(c_quot_q);
    end
    c_value = c_neg_q ? (32'd0 - c_mag) : c_mag;
    case (c_kind_q)
      rslp_pkg::KIND_VOLT, rslp_pkg::KIND_PHASE, rslp_pkg::KIND_TRIP: begin
      end
      rslp_pkg::KIND_FREQ, rslp_pkg::KIND_READY, rslp_pkg::KIND_MCLK: begin
        if (c_ovf_q) begin
          c_value = rslp_pkg::ALL_ONES;
        end
      end
      default: begin
        c_value = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid_q <= sum_valid_i;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_valid_i && b_ready) begin
      b_sum_q <= sum_i;
    end
    if (b_valid_q && c_ready) begin
      c_kind_q <= b_sum_q.event_kind;
      c_id_q   <= b_sum_q.node_id;
      c_base_q <= b_base;
      c_quot_q <= b_prod[rslp_pkg::VOLT_SHIFT +: rslp_pkg::QUOT_W];
      c_ovf_q  <= b_sum_q.overflow;
      c_neg_q  <= b_sum_q.negative;
    end
    if (c_valid_q && out_ready) begin
      out_data_q.parse_ok     <= (c_kind_q != rslp_pkg::KIND_NONE);
      out_data_q.event_kind   <= c_kind_q;
      out_data_q.node_id      <= c_id_q;
      out_data_q.status_value <= c_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> sv/remote_status_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remote status line parser
// Parses one text line per result: node prefix, run/stop commands and
// status keywords with a decimal value.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle while in_stall_o is low, with no gap between lines.
// Result path: after the line's last byte is accepted, the result beat passes
//   through the three-stage finishing pipeline (clamp and multiply, scale
//   and sign, output register), which the receiver can stall.
// Reset: line state returns to its idle values and the pipeline empties;
//   line state also clears after every last byte.
// ----------------------------------------------------------------------------
module remote_status_line_parser #(
  parameter int LINE_BYTES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  rslp_pkg::in_beat_t   in_data_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output rslp_pkg::out_beat_t  out_data_o,
  input  logic                 out_stall_i
);

  localparam int              CW        = $clog2(LINE_BYTES);
  localparam logic [CW-1:0]   COUNT_MAX = CW'(LINE_BYTES - 1);

  typedef enum logic [1:0] {
    PFX_START = 2'd0,
    PFX_MARK  = 2'd1,
    PFX_HEX   = 2'd2,
    PFX_DONE  = 2'd3
  } pfx_stage_e;

  typedef enum logic [2:0] {
    NUM_IDLE   = 3'd0,
    NUM_SEP    = 3'd1,
    NUM_WS     = 3'd2,
    NUM_DIGITS = 3'd3,
    NUM_DONE   = 3'd4
  } num_phase_e;

  logic [CW-1:0] count_q, count_d;
  logic          ended_q, ended_d;
  pfx_stage_e    pfx_q, pfx_d;
  logic [7:0]    id_q, id_d;
  logic [7:0]    alive_q, alive_d;
  logic [3:0]    off_q, off_d;
  num_phase_e    num_q, num_d;
  logic          neg_q, neg_d;
  logic [31:0]   mag_q, mag_d;
  logic          ovf_q, ovf_d;

  logic                in_acc;
  logic                sum_ready;
  rslp_pkg::line_sum_t sum;
  logic [7:0]          raw, ch;
  logic                is_dig, is_hex;
  logic [3:0]          hex_nib;
  logic [35:0]         dig_sum;
  logic                body, skip, do_add;
  logic [7:0]          keep;

  assign in_stall_o = !sum_ready;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign raw        = in_data_i.char_byte;

  always_comb begin
    ch      = (raw inside {[8'h41:8'h5A]}) ? (raw + 8'd32) : raw;
    is_dig  = (ch inside {["0":"9"]});
    is_hex  = (ch inside {["0":"9"], ["a":"f"]});
    hex_nib = is_dig ? ch[3:0] : (ch[3:0] + 4'd9);
    dig_sum = ({4'h0, mag_q} << 3) + ({4'h0, mag_q} << 1) + 36'(ch[3:0]);
  end

  always_comb begin
    count_d = count_q;
    ended_d = ended_q;
    pfx_d   = pfx_q;
    id_d    = id_q;
    alive_d = alive_q;
    off_d   = off_q;
    num_d   = num_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    ovf_d   = ovf_q;
    body    = 1'b0;
    skip    = 1'b0;
    do_add  = 1'b0;
    keep    = '0;
    sum     = '{event_kind: rslp_pkg::KIND_NONE, node_id: id_q, magnitude: mag_q,
                overflow: ovf_q, negative: neg_q};

    if (in_acc && !ended_q && (count_q < COUNT_MAX)) begin
      if (raw == 8'h00) begin
        ended_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
        body    = 1'b1;
        case (pfx_q)
          PFX_START: begin
            if (ch == "#" || ch == "@") begin
              pfx_d   = PFX_MARK;
              alive_d = '0;
              body    = 1'b0;
            end else begin
              pfx_d = PFX_DONE;
            end
          end
          PFX_MARK: begin
            pfx_d = PFX_DONE;
            body  = 1'b0;
            if (is_hex) begin
              id_d    = {4'h0, hex_nib};
              pfx_d   = PFX_HEX;
              alive_d = '1;
              off_d   = '0;
            end
          end
          PFX_HEX: begin
            if (is_hex) begin
              id_d = {4'h0, hex_nib};
            end else begin
              pfx_d = PFX_DONE;
            end
          end
          default: begin
          end
        endcase

        if (body) begin
          if (num_q != NUM_IDLE) begin
            num_d = num_q;
            if (num_d == NUM_SEP) begin
              if (ch == " " || ch == ":") begin
                skip = 1'b1;
              end else begin
                num_d = NUM_WS;
              end
            end
            if (!skip && num_d == NUM_WS) begin
              if (ch == " " || (ch inside {[8'd9:8'd13]})) begin
                num_d = NUM_WS;
              end else if (ch == "+" || ch == "-") begin
                neg_d = (ch == "-");
                num_d = NUM_DIGITS;
              end else if (is_dig) begin
                do_add = 1'b1;
                num_d  = NUM_DIGITS;
              end else begin
                num_d = NUM_DONE;
              end
            end else if (!skip && num_d == NUM_DIGITS) begin
              if (is_dig) begin
                do_add = 1'b1;
              end else begin
                num_d = NUM_DONE;
              end
            end
            if (do_add && !ovf_q) begin
              if (dig_sum[35:32] != 4'h0) begin
                ovf_d = 1'b1;
              end else begin
                mag_d = dig_sum[31:0];
              end
            end
          end else if (!(id_d != rslp_pkg::NO_NODE && off_q == 4'd0 &&
                         (ch == " " || ch == ":")) && alive_q != 8'h00) begin
            for (int i = 0; i < rslp_pkg::KW_COUNT; i++) begin
              keep[i] = alive_q[i] && (off_q < rslp_pkg::KW_LEN[i]) &&
                        (rslp_pkg::kw_char(3'(i), off_q) == ch);
            end
            alive_d = keep;
            off_d   = (off_q != 4'hF) ? (off_q + 4'd1) : off_q;
            for (int i = 2; i < rslp_pkg::KW_COUNT; i++) begin
              if (keep[i] && off_d == rslp_pkg::KW_LEN[i]) begin
                num_d = NUM_SEP;
              end
            end
          end
        end
      end
    end

    if (num_d != NUM_IDLE) begin
      for (int i = 2; i < rslp_pkg::KW_COUNT; i++) begin
        if (alive_d[i]) begin
          sum.event_kind = rslp_pkg::event_kind_e'(4'(i + 1));
        end
      end
    end else if (alive_d[0] && off_d == 4'd3) begin
      sum.event_kind = rslp_pkg::KIND_RUN;
    end else if (alive_d[1] && off_d == 4'd4) begin
      sum.event_kind = rslp_pkg::KIND_STOP;
    end
    sum.node_id   = id_d;
    sum.magnitude = mag_d;
    sum.overflow  = ovf_d;
    sum.negative  = neg_d;

    if (in_acc && in_data_i.line_end) begin
      count_d = '0;
      ended_d = 1'b0;
      pfx_d   = PFX_START;
      id_d    = rslp_pkg::NO_NODE;
      alive_d = '1;
      off_d   = '0;
      num_d   = NUM_IDLE;
      neg_d   = 1'b0;
      mag_d   = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ended_q <= 1'b0;
      pfx_q   <= PFX_START;
      id_q    <= rslp_pkg::NO_NODE;
      alive_q <= '1;
      off_q   <= '0;
      num_q   <= NUM_IDLE;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ended_q <= ended_d;
      pfx_q   <= pfx_d;
      id_q    <= id_d;
      alive_q <= alive_d;
      off_q   <= off_d;
      num_q   <= num_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      ovf_q   <= ovf_d;
    end
  end

  rslp_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (in_acc && in_data_i.line_end),
    .sum_i       (sum),
    .sum_ready_o (sum_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.line_end |=>
      count_q == '0 && alive_q == 8'hFF && num_q == NUM_IDLE && !ovf_q)
    else $error("line state not cleared after last beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    id_q == rslp_pkg::NO_NODE || id_q[7:4] == 4'h0)
    else $error("node id outside prefix range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_q != NUM_IDLE |-> alive_q[1:0] == 2'b00)
    else $error("command keyword alive during number parse");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.parse_ok |->
      out_data_o.status_value == '0 && out_data_o.event_kind == rslp_pkg::KIND_NONE)
    else $error("failed line carries a value or kind");

endmodule

>>> verif/rslp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remote status line parser checker
// Watches both beat channels, runs its own line model on every accepted
// input beat and compares each accepted result beat, field by field, with
// the oldest predicted result. Hands the failure count and the number of
// outstanding predictions to the testbench top.
// ----------------------------------------------------------------------------
module rslp_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  rslp_pkg::in_beat_t   in_data_i,
  input  logic                 in_stall_i,
  input  logic                 out_valid_i,
  input  rslp_pkg::out_beat_t  out_data_i,
  input  logic                 out_stall_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  import rslp_pkg::*;

  localparam int LINE_BYTES = 64;

  typedef enum logic [2:0] {
    NUM_IDLE, NUM_SEP, NUM_WS, NUM_DIGITS, NUM_DONE
  } num_phase_e;

  typedef enum logic [1:0] {
    PFX_FIRST, PFX_MARK, PFX_HEX, PFX_DONE
  } pfx_stage_e;

  logic [6:0]  bytes_taken;
  logic        text_over;
  pfx_stage_e  pfx;
  logic [7:0]  node;
  logic [7:0]  alive;
  logic [3:0]  matched;
  num_phase_e  nphase;
  logic        minus;
  logic [31:0] mag;
  logic        mag_ovf;
  out_beat_t   expected_lines[$];

  task automatic clear_line();
    bytes_taken = '0;
    text_over   = 1'b0;
    pfx         = PFX_FIRST;
    node        = NO_NODE;
    alive       = '1;
    matched     = '0;
    nphase      = NUM_IDLE;
    minus       = 1'b0;
    mag         = '0;
    mag_ovf     = 1'b0;
  endtask

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int hex_of(logic [7:0] c);
    if (is_digit(c)) return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  task automatic add_digit(input logic [7:0] c);
    logic [35:0] t;
    if (!mag_ovf) begin
      t = {4'b0, mag} * 36'd10 + 36'(c - "0");
      if (t > 36'hF_FFFF_FFFF >> 4) mag_ovf = 1'b1;
      else mag = t[31:0];
    end
  endtask

  task automatic number_step(input logic [7:0] c);
    if (nphase == NUM_SEP) begin
      if (c == " " || c == ":") return;
      nphase = NUM_WS;
    end
    if (nphase == NUM_WS) begin
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
      if (c == "+" || c == "-") begin
        minus  = (c == "-");
        nphase = NUM_DIGITS;
      end else if (is_digit(c)) begin
        add_digit(c);
        nphase = NUM_DIGITS;
      end else begin
        nphase = NUM_DONE;
      end
    end else if (nphase == NUM_DIGITS) begin
      if (is_digit(c)) add_digit(c);
      else nphase = NUM_DONE;
    end
  endtask

  task automatic keyword_step(input logic [7:0] c);
    logic [7:0] keep;
    keep = '0;
    if (alive == '0) return;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (alive[i] && matched < KW_LEN[i] && KW_TEXT[i][matched] == c) keep[i] = 1'b1;
    end
    alive = keep;
    if (matched < 4'd15) matched++;
    for (int i = 2; i < KW_COUNT; i++) begin
      if (alive[i] && matched == KW_LEN[i]) nphase = NUM_SEP;
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    int h;
    h = hex_of(c);
    case (pfx)
      PFX_FIRST: begin
        if (c == "#" || c == "@") begin
          pfx   = PFX_MARK;
          alive = '0;
          return;
        end
        pfx = PFX_DONE;
      end
      PFX_MARK: begin
        pfx = PFX_DONE;
        if (h >= 0) begin
          node    = 8'(h);
          pfx     = PFX_HEX;
          alive   = '1;
          matched = '0;
        end
        return;
      end
      PFX_HEX: begin
        if (h >= 0) node = 8'(h);
        else pfx = PFX_DONE;
      end
      default: ;
    endcase
    if (nphase != NUM_IDLE) begin
      number_step(c);
      return;
    end
    // skip separators ahead of the body of an addressed line
    if (node != NO_NODE && matched == '0 && (c == " " || c == ":")) return;
    keyword_step(c);
  endtask

  function automatic logic [31:0] status_of(event_kind_e kind);
    logic [31:0] m;
    if (kind == KIND_VOLT || kind == KIND_PHASE || kind == KIND_TRIP) begin
      m = mag_ovf ? SIGNED_MAX : mag;
      if (m > SIGNED_MAX) m = SIGNED_MAX;
      if (kind == KIND_VOLT) m = m / 32'd1000;
      return minus ? -m : m;
    end
    if (mag_ovf) return ALL_ONES;
    return minus ? -mag : mag;
  endfunction

  task automatic predict_beat(input in_beat_t b);
    logic [7:0]  c;
    event_kind_e kind;
    out_beat_t   r;
    c    = b.char_byte;
    kind = KIND_NONE;
    if (!text_over && bytes_taken < 7'(LINE_BYTES - 1)) begin
      if (c == 8'h00) begin
        text_over = 1'b1;
      end else begin
        if (c >= "A" && c <= "Z") c = c + 8'd32;
        take_char(c);
        bytes_taken++;
      end
    end
    if (b.line_end) begin
      r.status_value = '0;
      if (nphase != NUM_IDLE) begin
        for (int i = 2; i < KW_COUNT; i++) begin
          if (alive[i]) kind = event_kind_e'(i + 1);
        end
        if (kind != KIND_NONE) r.status_value = status_of(kind);
      end else if (alive[0] && matched == 4'd3) begin
        kind = KIND_RUN;
      end else if (alive[1] && matched == 4'd4) begin
        kind = KIND_STOP;
      end
      r.parse_ok   = (kind != KIND_NONE);
      r.event_kind = kind;
      r.node_id    = node;
      expected_lines.push_back(r);
      clear_line();
    end
  endtask

  task automatic compare_line(input out_beat_t want, input out_beat_t got);
    if (got.parse_ok !== want.parse_ok) begin
      $display("%0t: parse_ok expected %0d actual %0d", $time, want.parse_ok, got.parse_ok);
      fail_count_o++;
    end
    if (got.event_kind !== want.event_kind) begin
      $display("%0t: event_kind expected %0d actual %0d", $time,
               want.event_kind, got.event_kind);
      fail_count_o++;
    end
    if (got.node_id !== want.node_id) begin
      $display("%0t: node_id expected %0d actual %0d", $time, want.node_id, got.node_id);
      fail_count_o++;
    end
    if (got.status_value !== want.status_value) begin
      $display("%0t: status_value expected %h actual %h", $time,
               want.status_value, got.status_value);
      fail_count_o++;
    end
  endtask

  initial clear_line();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      expected_lines.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_lines.size() == 0) begin
          $display("%0t: result beat with none expected, actual %h", $time, out_data_i);
          fail_count_o++;
        end else begin
          compare_line(expected_lines.pop_front(), out_data_i);
        end
      end
      if (in_valid_i && !in_stall_i) predict_beat(in_data_i);
    end
    pending_o = expected_lines.size();
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remote status line parser testbench
// Sends directed lines (every command and status keyword, node prefixes,
// saturation, zero bytes, overlong lines) and then random lines, mostly
// well formed with random content, under random sender bursts and receiver
// stalls. The checker predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import rslp_pkg::*;

  localparam int BYTE_TARGET  = 1900;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  out_beat_t out_data;
  logic      out_stall = 1'b0;
  int        fail_count;
  int        pending;
  int        idle_cycles = 0;
  int        bytes_sent  = 0;
  int        burst_left  = 0;
  logic [9:0] stall_epoch = '0;
  int        hold_left   = 0;
  logic [7:0] line_buf[$];

  string keywords[KW_COUNT] = '{"run", "stop", "stat:volt", "stat:phas",
                                "stat:tcurr", "stat:freq", "stat:ready", "stat:mclk"};
  string edge_values[10] = '{"2147483647", "2147483648", "2147483000", "4294967295",
                             "4294967296", "999", "1000", "1999", "0", "99999999999"};
  string hex_chars = "0123456789abcdefABCDEF";

  remote_status_line_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_stall_i (out_stall)
  );

  rslp_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_data_i    (in_data),
    .in_stall_i   (in_stall),
    .out_valid_i  (out_valid),
    .out_data_i   (out_data),
    .out_stall_i  (out_stall),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern: free, random, periodic, then long runs
  always @(negedge clk_i) begin
    stall_epoch <= stall_epoch + 1'b1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      case (stall_epoch[9:8])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= (stall_epoch[2:0] == 3'd5);
        default: begin
          out_stall <= !out_stall;
          hold_left <= out_stall ? $urandom_range(0, 6) : $urandom_range(0, 12);
        end
      endcase
    end
  end

  task automatic push_beat(input logic [7:0] ch, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) gap = 20;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{char_byte: ch, line_end: last};
    // hold the beat until taken
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_line();
    for (int k = 0; k < line_buf.size(); k++) push_beat(line_buf[k], k == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic add_text(input string s, input bit mix_case);
    logic [7:0] ch;
    for (int k = 0; k < s.len(); k++) begin
      ch = s[k];
      if (mix_case && ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) ch = ch - 8'd32;
      line_buf.push_back(ch);
    end
  endtask

  task automatic add_seps(input int most);
    repeat ($urandom_range(0, most)) line_buf.push_back($urandom_range(0, 1) ? " " : ":");
  endtask

  task automatic add_number();
    int ndig;
    case ($urandom_range(0, 9))
      0:       add_text(edge_values[$urandom_range(0, 9)], 0);
      1, 2:    ndig = $urandom_range(4, 14);
      default: ndig = $urandom_range(0, 3);
    endcase
    repeat (ndig) line_buf.push_back(8'("0") + 8'($urandom_range(0, 9)));
  endtask

  task automatic build_random_line();
    int pick;
    int kw;
    int idx;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 9) < 4) begin
      line_buf.push_back($urandom_range(0, 1) ? "#" : "@");
      if ($urandom_range(0, 6) != 0) begin
        repeat ($urandom_range(1, 2)) line_buf.push_back(hex_chars[$urandom_range(0, 21)]);
      end else begin
        line_buf.push_back(8'($urandom_range(33, 126)));
      end
      add_seps(3);
    end else if ($urandom_range(0, 15) == 0) begin
      add_seps(1);
    end
    kw = $urandom_range(0, KW_COUNT - 1);
    add_text(keywords[kw], 1);
    if (kw >= 2) begin
      if (kw == 3 && $urandom_range(0, 5) == 0) line_buf.push_back("e");
      add_seps(2);
      repeat ($urandom_range(0, 2)) begin
        line_buf.push_back($urandom_range(0, 2) == 0 ? " " : 8'($urandom_range(9, 13)));
      end
      case ($urandom_range(0, 2))
        0: line_buf.push_back("+");
        1: line_buf.push_back("-");
        default: ;
      endcase
      add_number();
    end
    if (pick < 14) begin
      // long line: pad with spaces and digits, often past the point where bytes are dropped
      while (line_buf.size() < $urandom_range(60, 80)) begin
        line_buf.push_back($urandom_range(0, 2) == 0 ? " " : 8'("0") + 8'($urandom_range(0, 9)));
      end
    end
    if ($urandom_range(0, 4) == 0) line_buf.push_back(8'($urandom_range(1, 255)));
    if ($urandom_range(0, 6) == 0) begin
      idx = $urandom_range(0, line_buf.size() - 1);
      line_buf[idx] = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    add_text("run", 0);                        send_line();
    add_text("STOP", 0);                       send_line();
    add_text("#3run", 0);                      send_line();
    add_text("@a: stat:volt 12345", 0);        send_line();
    add_text("#F:: stop", 0);                  send_line();
    add_text("#xrun", 0);                      send_line();
    add_text("stat:phas -2147483648", 0);      send_line();
    add_text("stat:tcurr +99999999999", 0);    send_line();
    add_text("stat:freq 4294967295", 0);       send_line();
    add_text("stat:ready -5", 0);              send_line();
    add_text("stat:mclk 4294967296", 0);       send_line();
    add_text("stat:volt -999", 0);             send_line();
    add_text("stat:volt:: \t 4000x", 0);       send_line();
    add_text("stat:freq", 0);                  send_line();
    add_text("stat:phase 17", 0);              send_line();
    add_text("ru", 0);
    line_buf.push_back(8'h00);
    add_text("n", 0);                          send_line();
    add_text("stat:freq", 0);
    repeat (53) line_buf.push_back(" ");
    add_text("789", 0);                        send_line();
    line_buf.push_back(8'hFF);                 send_line();
    line_buf.push_back(8'h00);                 send_line();

    while (bytes_sent < BYTE_TARGET) begin
      build_random_line();
      send_line();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
sv/rslp_pkg.sv
sv/rslp_finish.sv
sv/remote_status_line_parser.sv
verif/rslp_checker.sv
verif/tb_top.sv
